[sv/matrix_diagonal_zigzag_scan_macros.svh]
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_scan_macros.svh
// Assertion macros for the zigzag scan block. They are empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MATRIX_DIAGONAL_ZIGZAG_SCAN_MACROS_SVH
`define MATRIX_DIAGONAL_ZIGZAG_SCAN_MACROS_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define MDZZ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define MDZZ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MDZZ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define MDZZ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[sv/mdzz_pkg.sv]
// ----------------------------------------------------------------------------
// mdzz_pkg
// Shared types, constants and helpers for the zigzag scan block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdzz_pkg;

  localparam int unsigned MAX_ROWS_DEF = 8;
  localparam int unsigned MAX_COLS_DEF = 8;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;

  // register indexes (paddr[2])
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RST = 4'd8;

  // scan job handed from front to back
  typedef struct packed {
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] col_count;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

  // zero acts as one, anything above maxv acts as maxv
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned r;
    r = int'(v);
    if (r == 0) begin
      r = 1;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/mdzz_ram.sv]
// ----------------------------------------------------------------------------
// mdzz_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdzz_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/mdzz_front.sv]
// ----------------------------------------------------------------------------
// mdzz_front
// Load side: writes each word into the store and queues a scan job when
// the matrix is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module mdzz_front #(
  parameter int unsigned MAX_ROWS = mdzz_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mdzz_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   hold,
  input  logic [mdzz_pkg::DATA_W-1:0]            elem_value,
  input  logic [mdzz_pkg::CFG_W-1:0]             row_count,
  input  logic [mdzz_pkg::CFG_W-1:0]             col_count,
  output logic                                   ram_we,
  output logic [((MAX_ROWS*MAX_COLS > 1) ?
                 $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] ram_waddr,
  output logic [mdzz_pkg::DATA_W-1:0]            ram_wdata,
  output logic                                   push,
  output mdzz_pkg::job_t                         push_job
);

  import mdzz_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW    = $clog2(DEPTH + 1);

  logic [TW-1:0] load_count;
  logic [TW-1:0] load_count_next;
  logic [TW-1:0] count_inc;
  logic [TW-1:0] total;
  logic          accept;
  logic          complete;

  assign accept    = start && !hold;
  assign total     = TW'(clamp_dim(row_count, MAX_ROWS)) *
                     TW'(clamp_dim(col_count, MAX_COLS));
  assign count_inc = load_count + TW'(1);
  assign complete  = (count_inc >= total);

  assign ram_we    = accept;
  assign ram_waddr = load_count[AW-1:0];
  assign ram_wdata = elem_value;

  assign push               = accept && complete;
  assign push_job.row_count = row_count;
  assign push_job.col_count = col_count;

  always_comb begin
    load_count_next = load_count;
    if (accept) begin
      load_count_next = complete ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else begin
      load_count <= load_count_next;
    end
  end

endmodule

`default_nettype wire

[sv/mdzz_queue.sv]
// ----------------------------------------------------------------------------
// mdzz_queue
// Two-entry job queue between load side and scan side.
// ----------------------------------------------------------------------------
`default_nettype none

module mdzz_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mdzz_pkg::job_t push_job,
  input  logic           pop,
  output logic           q_valid,
  output mdzz_pkg::job_t q_job
);

  import mdzz_pkg::*;

  job_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign q_valid = (fill != 2'd0);
  assign q_job   = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/mdzz_back.sv]
// ----------------------------------------------------------------------------
// mdzz_back
// Scan side: walks the matrix in diagonal zigzag order, one store read per
// cycle, and emits one result word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mdzz_back #(
  parameter int unsigned MAX_ROWS = mdzz_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mdzz_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  mdzz_pkg::job_t                         q_job,
  output logic                                   pop,
  output logic [((MAX_ROWS*MAX_COLS > 1) ?
                 $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] ram_raddr,
  input  logic [mdzz_pkg::DATA_W-1:0]            ram_rdata,
  output logic                                   active,
  output logic                                   out_strobe,
  output logic signed [mdzz_pkg::DATA_W-1:0]     out_value,
  output logic [mdzz_pkg::OUT_IDX_W-1:0]         out_row,
  output logic [mdzz_pkg::OUT_IDX_W-1:0]         out_col,
  output logic                                   out_last
);

  import mdzz_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1);

  bk_state_t      state, state_next;
  logic [RIW-1:0] row, row_next;
  logic [CIW-1:0] col, col_next;
  logic           up, up_next;
  logic [AW-1:0]  k, k_next;
  logic [RIW-1:0] rows_m1, rows_m1_next;
  logic [CIW-1:0] cols_m1, cols_m1_next;
  logic [CCW-1:0] cols, cols_next;
  logic [AW-1:0]  total_m1, total_m1_next;
  logic           st_valid, st_valid_next;
  logic [RIW-1:0] st_row;
  logic [CIW-1:0] st_col;
  logic           st_last;
  logic           at_end;
  int unsigned    dim_r;
  int unsigned    dim_c;

  assign dim_r  = clamp_dim(q_job.row_count, MAX_ROWS);
  assign dim_c  = clamp_dim(q_job.col_count, MAX_COLS);
  assign at_end = (k == total_m1);

  assign ram_raddr = AW'(row) * AW'(cols) + AW'(col);

  assign active     = (state == BK_SCAN) || st_valid;
  assign out_strobe = st_valid;
  assign out_value  = $signed(ram_rdata);
  assign out_row    = OUT_IDX_W'(st_row);
  assign out_col    = OUT_IDX_W'(st_col);
  assign out_last   = st_last;

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    up_next       = up;
    k_next        = k;
    rows_m1_next  = rows_m1;
    cols_m1_next  = cols_m1;
    cols_next     = cols;
    total_m1_next = total_m1;
    st_valid_next = 1'b0;
    pop           = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop           = 1'b1;
          rows_m1_next  = RIW'(dim_r - 1);
          cols_m1_next  = CIW'(dim_c - 1);
          cols_next     = CCW'(dim_c);
          total_m1_next = AW'(dim_r * dim_c - 1);
          row_next      = '0;
          col_next      = '0;
          up_next       = 1'b1;
          k_next        = '0;
          state_next    = BK_SCAN;
        end
      end
      BK_SCAN: begin
        st_valid_next = 1'b1;
        k_next        = k + AW'(1);
        if (at_end) begin
          state_next = BK_IDLE;
        end
        if (up) begin
          priority if (col == cols_m1) begin
            row_next = row + RIW'(1);
            up_next  = 1'b0;
          end else if (row == '0) begin
            col_next = col + CIW'(1);
            up_next  = 1'b0;
          end else begin
            row_next = row - RIW'(1);
            col_next = col + CIW'(1);
          end
        end else begin
          priority if (row == rows_m1) begin
            col_next = col + CIW'(1);
            up_next  = 1'b1;
          end else if (col == '0) begin
            row_next = row + RIW'(1);
            up_next  = 1'b1;
          end else begin
            row_next = row + RIW'(1);
            col_next = col - CIW'(1);
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      st_valid <= 1'b0;
    end else begin
      state    <= state_next;
      st_valid <= st_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    row      <= row_next;
    col      <= col_next;
    up       <= up_next;
    k        <= k_next;
    rows_m1  <= rows_m1_next;
    cols_m1  <= cols_m1_next;
    cols     <= cols_next;
    total_m1 <= total_m1_next;
    st_row   <= row;
    st_col   <= col;
    st_last  <= at_end;
  end

endmodule

`default_nettype wire

[sv/matrix_diagonal_zigzag_scan.sv]
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_scan
// Loads a matrix in row-major order and emits it in diagonal zigzag order.
//
//   channel  handshake                     words
//   in       start & !busy                 elem_value
//   out      out_strobe (one cycle)        out_value, out_row, out_col, out_last
//   cfg      psel & penable & pwrite       row_count @0x0, col_count @0x4
//
// A word that does not complete the matrix leaves busy low, so the next word can be taken straight after it.
// The completing word queues a scan job and raises busy until the scan
// is through; results follow one per cycle, paced by the single store
// read port of the scan sequencer.
// Synchronous reset; the matrix store is not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_diagonal_zigzag_scan_macros.svh"

module matrix_diagonal_zigzag_scan #(
  parameter int unsigned MAX_ROWS = mdzz_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = mdzz_pkg::MAX_COLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [mdzz_pkg::DATA_W-1:0]    elem_value,
  output logic                                  out_strobe,
  output logic signed [mdzz_pkg::DATA_W-1:0]    out_value,
  output logic [mdzz_pkg::OUT_IDX_W-1:0]        out_row,
  output logic [mdzz_pkg::OUT_IDX_W-1:0]        out_col,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mdzz_pkg::PADDR_W-1:0]          paddr,
  input  logic [mdzz_pkg::APB_W-1:0]            pwdata,
  output logic [mdzz_pkg::APB_W-1:0]            prdata,
  output logic                                  pready
);

  import mdzz_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]  row_count;
  logic [CFG_W-1:0]  col_count;
  logic              cfg_wr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              push;
  job_t              push_job;
  logic              pop;
  logic              q_valid;
  job_t              q_job;
  logic              back_active;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_RST;
      col_count <= DIM_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: row_count <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: col_count <= pwdata[CFG_W-1:0];
        default:       row_count <= row_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = APB_W'(row_count);
      REG_COL_COUNT: prdata = APB_W'(col_count);
      default:       prdata = '0;
    endcase
  end

  assign busy = q_valid || back_active;

  mdzz_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .hold       (busy),
    .elem_value (elem_value),
    .row_count  (row_count),
    .col_count  (col_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .push       (push),
    .push_job   (push_job)
  );

  mdzz_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mdzz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  mdzz_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .active     (back_active),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last)
  );

  `MDZZ_ASSERT_IMP(a_strobe_busy, clk, rst, out_strobe, busy, "result word while not busy")
  `MDZZ_ASSERT_NXT(a_push_busy, clk, rst, push, busy, "scan job queued but block not busy")
  `MDZZ_ASSERT_NXT(a_last_ends, clk, rst, out_strobe && out_last, !out_strobe, "word after last")
  `MDZZ_ASSERT_NXT(a_no_gap, clk, rst, out_strobe && !out_last, out_strobe, "gap in scan output")

endmodule

`default_nettype wire

[tb/matrix_diagonal_zigzag_scan_checker.sv]
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_scan_checker
// Watches the element, result and register ports of the zigzag scan block.
// Keeps its own copy of the matrix store, fill count and dimension registers.
// On each completing word it queues the expected zigzag walk. Every result word
// is compared field by field with the head of that queue, and register reads
// are compared with the copy.
// ----------------------------------------------------------------------------
module matrix_diagonal_zigzag_scan_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [mdzz_pkg::DATA_W-1:0]  elem_value,
  input  logic                                out_strobe,
  input  logic signed [mdzz_pkg::DATA_W-1:0]  out_value,
  input  logic [mdzz_pkg::OUT_IDX_W-1:0]      out_row,
  input  logic [mdzz_pkg::OUT_IDX_W-1:0]      out_col,
  input  logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mdzz_pkg::PADDR_W-1:0]        paddr,
  input  logic [mdzz_pkg::APB_W-1:0]          pwdata,
  input  logic [mdzz_pkg::APB_W-1:0]          prdata,
  input  logic                                pready,
  output int                                  mismatch_count,
  output int                                  words_owed
);

  import mdzz_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic                     last;
  } scan_word_t;

  scan_word_t        zigzag_queue[$];
  scan_word_t        head;
  logic [DATA_W-1:0] matrix_mem[MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [6:0]        fill_count;
  logic [CFG_W-1:0]  row_reg;
  logic [CFG_W-1:0]  col_reg;
  logic [CFG_W-1:0]  reg_seen;

  initial begin
    mismatch_count = 0;
    words_owed = 0;
  end

  function automatic int unsigned dim_in_force(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
    if (v == '0) begin
      return 1;
    end
    if (v > maxv) begin
      return maxv;
    end
    return v;
  endfunction

  task automatic queue_zigzag(input int unsigned rows, input int unsigned cols);
    int unsigned r;
    int unsigned c;
    int unsigned k;
    bit          up;
    scan_word_t  w;
    r = 0;
    c = 0;
    up = 1'b1;
    for (k = 0; k < rows * cols; k++) begin
      w.value = matrix_mem[r * cols + c];
      w.row = r[OUT_IDX_W-1:0];
      w.col = c[OUT_IDX_W-1:0];
      w.last = (k == rows * cols - 1);
      zigzag_queue.insert(zigzag_queue.size(), w);
      if (up) begin
        if (c == cols - 1) begin
          r++;
          up = 1'b0;
        end else if (r == 0) begin
          c++;
          up = 1'b0;
        end else begin
          r--;
          c++;
        end
      end else begin
        if (r == rows - 1) begin
          c++;
          up = 1'b1;
        end else if (c == 0) begin
          r++;
          up = 1'b1;
        end else begin
          r++;
          c--;
        end
      end
    end
  endtask

  task automatic load_elem(input logic [DATA_W-1:0] v);
    int unsigned rows;
    int unsigned cols;
    rows = dim_in_force(row_reg, MAX_ROWS_DEF);
    cols = dim_in_force(col_reg, MAX_COLS_DEF);
    if (fill_count < MAX_ROWS_DEF * MAX_COLS_DEF) begin
      matrix_mem[fill_count] = v;
    end
    fill_count = fill_count + 7'd1;
    if (fill_count >= rows * cols) begin
      queue_zigzag(rows, cols);
      fill_count = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      zigzag_queue.delete();
      fill_count = '0;
      row_reg = DIM_RST;
      col_reg = DIM_RST;
    end else begin
      if (out_strobe) begin
        if (zigzag_queue.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: expected none, got value %0d row %0d col %0d last %0d",
                   $time, out_value, out_row, out_col, out_last);
        end else begin
          head = zigzag_queue.pop_front();
          if (out_value !== head.value) begin
            mismatch_count++;
            $display("%0t: out_value expected %0d got %0d", $time, head.value, out_value);
          end
          if (out_row !== head.row) begin
            mismatch_count++;
            $display("%0t: out_row expected %0d got %0d", $time, head.row, out_row);
          end
          if (out_col !== head.col) begin
            mismatch_count++;
            $display("%0t: out_col expected %0d got %0d", $time, head.col, out_col);
          end
          if (out_last !== head.last) begin
            mismatch_count++;
            $display("%0t: out_last expected %0d got %0d", $time, head.last, out_last);
          end
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_ROW_COUNT) begin
            row_reg = pwdata[CFG_W-1:0];
          end else begin
            col_reg = pwdata[CFG_W-1:0];
          end
        end else begin
          reg_seen = (paddr[2] == REG_ROW_COUNT) ? row_reg : col_reg;
          if (prdata[CFG_W-1:0] !== reg_seen) begin
            mismatch_count++;
            $display("%0t: prdata at %0d expected %0d got %0d",
                     $time, paddr, reg_seen, prdata[CFG_W-1:0]);
          end
        end
      end
      if (start && !busy) begin
        load_elem(elem_value);
      end
    end
    words_owed = zigzag_queue.size();
  end

endmodule

[tb/matrix_diagonal_zigzag_scan_test.sv]
// ----------------------------------------------------------------------------
// matrix_diagonal_zigzag_scan_test
// Drives matrices of many shapes into the zigzag scan block.
// A short directed pass covers extreme values, zero and oversized dimensions
// and a dimension change in mid-load. Random phases with random shapes follow,
// under three sender idle profiles. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module matrix_diagonal_zigzag_scan_test;
  import mdzz_pkg::*;

  localparam int ITEM_GOAL = 310;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] elem_value = '0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_value;
  logic [OUT_IDX_W-1:0]     out_row;
  logic [OUT_IDX_W-1:0]     out_col;
  logic                     out_last;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [APB_W-1:0]         pwdata = '0;
  logic [APB_W-1:0]         prdata;
  logic                     pready;
  int                       mismatch_count;
  int                       words_owed;
  int                       idle_pct = 16;
  int                       words_sent = 0;

  always #5 clk = ~clk;

  matrix_diagonal_zigzag_scan i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .elem_value(elem_value),
    .out_strobe(out_strobe), .out_value(out_value), .out_row(out_row),
    .out_col(out_col), .out_last(out_last), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  matrix_diagonal_zigzag_scan_checker i_scan_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .elem_value(elem_value),
    .out_strobe(out_strobe), .out_value(out_value), .out_row(out_row),
    .out_col(out_col), .out_last(out_last), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .words_owed(words_owed)
  );

  function automatic int unsigned dim_used(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(11))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // all results in and the block idle, then a settling wait for a word still being loaded
  task automatic wait_drained();
    start = 1'b0;
    while (words_owed != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_dim(input logic idx, input logic [CFG_W-1:0] dim);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = $urandom;
    pwdata[CFG_W-1:0] = dim;
    @(negedge clk);
    penable = 1'b1;
    while (!pready) @(negedge clk);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    while (!pready) @(negedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic feed_elem(input logic [DATA_W-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      elem_value = $urandom;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    elem_value = v;
    while (busy) @(negedge clk);
    @(negedge clk);
    words_sent++;
    if (words_sent >= 2 * ITEM_GOAL / 3) begin
      idle_pct = 0;
    end else if (words_sent >= ITEM_GOAL / 3) begin
      idle_pct = 55;
    end
  endtask

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int               phase;
    int unsigned      total;
    int unsigned      n;
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] c;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // zero rows acts as one row
    set_dim(REG_ROW_COUNT, 4'd0);
    set_dim(REG_COL_COUNT, 4'd1);
    feed_elem(32'h7fff_ffff);
    feed_elem(32'h8000_0000);
    set_dim(REG_ROW_COUNT, 4'd2);
    set_dim(REG_COL_COUNT, 4'd3);
    feed_elem('0);
    feed_elem('1);
    feed_elem(32'h0000_0001);
    feed_elem(32'hffff_fffe);
    feed_elem(32'h5555_5555);
    feed_elem(32'haaaa_aaaa);
    // oversized rows clamp to the maximum, zero columns act as one
    set_dim(REG_ROW_COUNT, 4'd15);
    set_dim(REG_COL_COUNT, 4'd0);
    repeat (8) feed_elem(pick_value());
    // shrink the matrix in mid-load: the next word completes the smaller one
    set_dim(REG_ROW_COUNT, 4'd4);
    set_dim(REG_COL_COUNT, 4'd4);
    repeat (5) feed_elem(pick_value());
    set_dim(REG_ROW_COUNT, 4'd2);
    set_dim(REG_COL_COUNT, 4'd2);
    feed_elem(pick_value());

    phase = 0;
    while (words_sent < ITEM_GOAL) begin
      r = CFG_W'($urandom_range(0, 5));
      c = CFG_W'($urandom_range(0, 5));
      if (phase % 8 == 7) begin
        r = $urandom_range(0, 1) ? 4'd15 : 4'd8;
        c = CFG_W'($urandom_range(8, 15));
      end else if (phase % 4 == 1) begin
        r = CFG_W'($urandom_range(8, 15));
      end else if (phase % 4 == 3) begin
        c = CFG_W'($urandom_range(8, 15));
      end
      set_dim(REG_ROW_COUNT, r);
      set_dim(REG_COL_COUNT, c);
      total = dim_used(r) * dim_used(c);
      n = (total > 16) ? 1 : $urandom_range(1, 4);
      repeat (n * total) begin
        if (words_sent < ITEM_GOAL) begin
          feed_elem(pick_value());
        end
      end
      if (total > 1 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, total - 1)) begin
          if (words_sent < ITEM_GOAL) begin
            feed_elem(pick_value());
          end
        end
      end
      phase++;
    end

    start = 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
